/* src/abl_pkg.sv */
`timescale 1ns / 1ps
// Package for the address blocklist: widths, defaults, operation and status codes,
// and the request and table status structures. No dependencies.
package abl_pkg;

   localparam int ADDR_W            = 32;
   localparam int TIME_W            = 32;
   localparam int DEF_TABLE_ENTRIES = 64;
   localparam logic [TIME_W-1:0] BASE_TIME_RESET = TIME_W'(60000);

   typedef enum logic [1:0] {
      MODE_REGISTER   = 2'd0,
      MODE_UNREGISTER = 2'd1,
      MODE_QUERY      = 2'd2,
      MODE_TICK       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // request as held in the input register
   typedef struct packed {
      logic              active;
      mode_type          mode;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] sum;
      logic [TIME_W-1:0] elapsed;
   } op_type;

   typedef struct packed {
      logic any_hit;
      logic full;
   } tbl_stat_type;

endpackage

/* src/abl_cell.sv */
`timescale 1ns / 1ps
// One table slot: valid bit, address, remaining time, with its own compare and
// saturating decrement. Depends on abl_pkg.
module abl_cell (
   input  logic           clock,
   input  logic           reset,
   input  abl_pkg::op_type op,
   input  logic           alloc,
   output logic           valid,
   output logic           hit
);
   import abl_pkg::*;

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic              expire;

   assign valid  = valid_ff;
   assign hit    = valid_ff && (addr_ff == op.addr);
   assign expire = (rem_ff <= op.elapsed);

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      if (op.active) begin
         case (op.mode)
            MODE_TICK: begin
               if (valid_ff) begin
                  if (expire) begin
                     valid_in = 1'b0;
                     rem_in   = '0;
                  end else begin
                     rem_in = rem_ff - op.elapsed;
                  end
               end
            end
            MODE_UNREGISTER: begin
               if (hit) begin
                  valid_in = 1'b0;
               end
            end
            MODE_REGISTER: begin
               if (alloc) begin
                  valid_in = 1'b1;
                  addr_in  = op.addr;
                  rem_in   = op.sum;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
   end

endmodule

/* src/abl_table.sv */
`timescale 1ns / 1ps
// Row of table slots with hit reduction and lowest-free-slot selection.
// Depends on abl_pkg and abl_cell.
module abl_table #(
   parameter int ENTRIES = abl_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  abl_pkg::op_type       op,
   output abl_pkg::tbl_stat_type stat
);
   import abl_pkg::*;

   logic [ENTRIES-1:0] valid;
   logic [ENTRIES-1:0] hit;
   logic [ENTRIES-1:0] lowest_free;
   logic [ENTRIES-1:0] alloc;
   logic               do_alloc;

   // isolate lowest clear bit of valid
   assign lowest_free = ~valid & (valid + ENTRIES'(1));
   assign stat.any_hit = |hit;
   assign stat.full    = &valid;
   assign do_alloc     = op.active && (op.mode == MODE_REGISTER) && !stat.any_hit;
   assign alloc        = do_alloc ? lowest_free : '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      abl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .op    (op),
         .alloc (alloc[i]),
         .valid (valid[i]),
         .hit   (hit[i])
      );
   end

endmodule

/* src/address_blocklist_with_expiry.sv */
`timescale 1ns / 1ps
// Top level of the address blocklist with expiry timers: request register,
// slot table and result register. Depends on abl_pkg and abl_table.
//
//  channel   ports                                    handshake
//  request   req_mode/ip_address/extra_time/elapsed   start & !busy
//  result    rsp_status, rsp_was_present              rsp_strobe, one cycle
//  config    csr_data                                 csr_valid & csr_ready
//
// One request per cycle while busy is low; its result strobes once it has passed
// the request register, then the slot table update and the result register.
// Reset is synchronous: it clears every slot's valid bit and loads the base
// time of 60000; busy is high and csr_ready low while reset is asserted.
// Results cannot be held off, so nothing stalls the request side.
module address_blocklist_with_expiry #(
   parameter int TABLE_ENTRIES = abl_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  logic [abl_pkg::ADDR_W-1:0] req_ip_address,
   input  logic [abl_pkg::TIME_W-1:0] req_extra_time,
   input  logic [abl_pkg::TIME_W-1:0] req_elapsed_ms,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_was_present,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [abl_pkg::TIME_W-1:0] csr_data
);
   import abl_pkg::*;

   logic [TIME_W-1:0] base_ff, base_in;
   op_type            op_ff, op_in;
   tbl_stat_type      stat;
   logic [TIME_W:0]   raw_sum;
   logic              strobe_ff, strobe_in;
   status_type        status_ff, status_in;
   logic              present_ff, present_in;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign base_in   = (csr_valid && csr_ready) ? csr_data : base_ff;

   // saturating total block time
   assign raw_sum = {1'b0, base_ff} + {1'b0, req_extra_time};

   always_comb begin
      op_in.active  = start && !busy;
      op_in.mode    = mode_type'(req_mode);
      op_in.addr    = req_ip_address;
      op_in.sum     = raw_sum[TIME_W] ? '1 : raw_sum[TIME_W-1:0];
      op_in.elapsed = req_elapsed_ms;
   end

   abl_table #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .op    (op_ff),
      .stat  (stat)
   );

   always_comb begin
      strobe_in  = op_ff.active;
      status_in  = STATUS_DONE;
      present_in = 1'b0;
      case (op_ff.mode)
         MODE_TICK: begin
         end
         MODE_REGISTER: begin
            present_in = stat.any_hit;
            if (stat.any_hit) begin
               status_in = STATUS_PRESENT;
            end else if (stat.full) begin
               status_in = STATUS_FULL;
            end
         end
         default: begin
            present_in = stat.any_hit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_TIME_RESET;
         op_ff.active <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         base_ff   <= base_in;
         op_ff     <= op_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      present_ff <= present_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_was_present = present_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted request produced no result");

   a_dup_register: assert property (@(posedge clock) disable iff (reset)
      (op_ff.active && op_ff.mode == MODE_REGISTER && stat.any_hit)
      |=> (rsp_status == STATUS_PRESENT && rsp_was_present))
      else $error("register of present address not reported");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (op_ff.active && op_ff.mode == MODE_TICK)
      |=> (rsp_status == STATUS_DONE && !rsp_was_present))
      else $error("tick result not plain done");

endmodule
